// ===== rtl/median3x3_first_channel_unit_macros.svh =====
// ------------------------------------------------------------------------
// median3x3_first_channel_unit_macros.svh
// Assertion macros shared by the median filter RTL.
// ------------------------------------------------------------------------
`ifndef MEDIAN3X3_FIRST_CHANNEL_UNIT_MACROS_SVH
`define MEDIAN3X3_FIRST_CHANNEL_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define MED3FC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("med3fc: assertion failed");
// Check that a condition in one cycle leads to a consequence in the next.
`define MED3FC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("med3fc: assertion failed");
`else
`define MED3FC_ASSERT(lbl, prop)
`define MED3FC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/med3fc_pkg.sv =====
// ------------------------------------------------------------------------
// med3fc_pkg
// Types, constants and compare helpers of the 3x3 median filter.
// ------------------------------------------------------------------------
`default_nettype none

package med3fc_pkg;

    // Beat payloads
    typedef struct packed {
        logic       flush;
        logic [7:0] chan_first;
        logic [7:0] chan_second;
        logic [7:0] chan_third;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [7:0] out_third;
        logic       frame_end;
    } t_pix_out;

    // One window column, sorted, plus its middle-row sample
    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] mid;
        logic [7:0] lo;
        logic [7:0] ctr;
    } t_col;

    // Window columns held in cells; the third column is the incoming one
    localparam int N_CELLS = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IDX_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_IDX_HEIGHT = 2'd1;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
    localparam int MIN_DIM = 3;

    // Row counter runs one past the height while draining
    localparam int ROW_W = HEIGHT_REG_W + 1;

    // Line store entry: newer row pixel (24 bits) over older row first byte
    localparam int PIX_W   = 24;
    localparam int ENTRY_W = PIX_W + 8;

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_col sort3(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c, input logic [7:0] ctr);
        t_col       s;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        logic [7:0] t;
        x = a;
        y = b;
        z = c;
        if (x > y) begin
            t = x; x = y; y = t;
        end
        if (y > z) begin
            t = y; y = z; z = t;
        end
        if (x > y) begin
            t = x; x = y; y = t;
        end
        s.lo  = x;
        s.mid = y;
        s.hi  = z;
        s.ctr = ctr;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/med3fc_stream_if.sv =====
// ------------------------------------------------------------------------
// med3fc_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ------------------------------------------------------------------------
`default_nettype none

interface med3fc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/med3fc_ram.sv =====
// ------------------------------------------------------------------------
// med3fc_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------
`default_nettype none

module med3fc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/med3fc_col_cell.sv =====
// ------------------------------------------------------------------------
// med3fc_col_cell
// One window column cell: hold a sorted column, pass it on each step.
// ------------------------------------------------------------------------
`default_nettype none

module med3fc_col_cell
    import med3fc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_col i_col,
    output t_col      o_col
);

    t_col r_col;
    t_col n_col;

    always_comb begin
        n_col = r_col;
        if (i_en) begin
            n_col = i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// ===== rtl/med3fc_median.sv =====
// ------------------------------------------------------------------------
// med3fc_median
// Median of nine from three sorted columns.
// ------------------------------------------------------------------------
`default_nettype none

module med3fc_median
    import med3fc_pkg::*;
(
    input  wire t_col       i_col_a,
    input  wire t_col       i_col_b,
    input  wire t_col       i_col_c,
    output logic [7:0]      o_median
);

    logic [7:0] lo_max;
    logic [7:0] mid_med;
    logic [7:0] hi_min;

    // Largest low, median of middles, smallest high; their median is the result
    assign lo_max   = max2(max2(i_col_a.lo, i_col_b.lo), i_col_c.lo);
    assign mid_med  = med3(i_col_a.mid, i_col_b.mid, i_col_c.mid);
    assign hi_min   = min2(min2(i_col_a.hi, i_col_b.hi), i_col_c.hi);
    assign o_median = med3(lo_max, mid_med, hi_min);

endmodule

`default_nettype wire

// ===== rtl/median3x3_first_channel_unit.sv =====
// Latency: a pixel leaves width + 1 accepted beats after it entered, then passes
// through the output register; drain with width + 1 beats after the frame.
// Throughput: one beat per cycle while the output register can take it, set by
// the line store (one read, one write per cycle) and the two-cell window shift.
// Reset: synchronous; clears counters, window and output valid, loads 640x480.
// ------------------------------------------------------------------------
// median3x3_first_channel_unit
// 3x3 median filter on the first channel of a three-channel pixel stream.
// Line store rows feed a chain of column cells; a median network selects
// the result for interior pixels, border pixels pass unchanged.
// ------------------------------------------------------------------------
`default_nettype none

`include "median3x3_first_channel_unit_macros.svh"

module median3x3_first_channel_unit
    import med3fc_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    med3fc_stream_if.sink              i_pix,
    med3fc_stream_if.source            o_pix
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

    // Configuration
    logic [WIDTH_REG_W-1:0]  r_cfg_width,  n_cfg_width;
    logic [HEIGHT_REG_W-1:0] r_cfg_height, n_cfg_height;

    // Frame position and the position of the previous step
    logic [CW-1:0]    r_col,       n_col;
    logic [ROW_W-1:0] r_row,       n_row;
    logic [CW-1:0]    r_prev_col,  n_prev_col;
    logic [ROW_W-1:0] r_prev_row,  n_prev_row;
    logic             r_prev_valid, n_prev_valid;
    logic [15:0]      r_center,    n_center;

    // Output register
    logic     r_out_valid, n_out_valid;
    t_pix_out r_out_data,  n_out_data;

    // Effective dimensions
    logic [CMPW-1:0]         w_clamp;
    logic [WW-1:0]           w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic [ROW_W-1:0]        h_ext;

    logic accept;
    logic cfg_hit;
    logic draining;
    logic step;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [PIX_W-1:0]   pix;

    logic [ROW_W-1:0] out_row;
    logic [WW-1:0]    out_col;
    logic             emit;
    logic             interior;
    logic             last;
    logic [WW-1:0]    col_inc;
    logic             wrap;

    t_col       new_col;
    t_col       chain [N_CELLS+1];
    logic [7:0] median;

    // Clamp width into 3..MAX_WIDTH, raise height to at least 3
    always_comb begin
        w_clamp = CMPW'(r_cfg_width);
        if (w_clamp < CMPW'(MIN_DIM)) begin
            w_clamp = CMPW'(MIN_DIM);
        end else if (w_clamp > CMPW'(MAX_WIDTH)) begin
            w_clamp = CMPW'(MAX_WIDTH);
        end
    end
    assign w_eff = WW'(w_clamp);
    assign h_eff = (r_cfg_height < HEIGHT_REG_W'(MIN_DIM)) ? HEIGHT_REG_W'(MIN_DIM)
                                                          : r_cfg_height;
    assign h_ext = ROW_W'(h_eff);

    // Take a beat whenever the output register is free or being drained
    assign i_pix.ready = !r_out_valid || o_pix.ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign cfg_hit     = i_cfg_we && (i_cfg_idx == CFG_IDX_WIDTH ||
                                      i_cfg_idx == CFG_IDX_HEIGHT);
    assign draining    = r_row >= h_ext;

    // Drop flush beats while the frame still expects pixels; after the last
    // pixel every beat drains one delayed pixel
    assign step = accept && !cfg_hit && (draining || !i_pix.data.flush);
    assign pix  = draining ? '0 : {i_pix.data.chan_third, i_pix.data.chan_second,
                                   i_pix.data.chan_first};

    // Line stores: read address runs one step ahead, so data of the
    // current column waits at the RAM output when the beat arrives
    assign ram_wdata = {pix, ram_rdata[15:8]};

    med3fc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (step),
        .i_waddr (r_col),
        .i_wdata (ram_wdata),
        .i_raddr (n_col),
        .o_rdata (ram_rdata)
    );

    // Incoming column: older row, newer row, current pixel
    assign new_col  = sort3(ram_rdata[7:0], ram_rdata[15:8], pix[7:0], ram_rdata[15:8]);
    assign chain[0] = new_col;

    // Window cells: chain[1] is the newest held column, chain[2] the oldest
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        med3fc_col_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (step),
            .i_col   (chain[g]),
            .o_col   (chain[g+1])
        );
    end

    med3fc_median u_median (
        .i_col_a  (new_col),
        .i_col_b  (chain[1]),
        .i_col_c  (chain[2]),
        .o_median (median)
    );

    // The result of this step belongs to the previous step's pixel, one row up
    assign emit     = r_prev_valid && (r_prev_row != '0);
    assign out_row  = r_prev_row - ROW_W'(1);
    assign out_col  = WW'(r_prev_col);
    assign interior = (out_row >= ROW_W'(1)) && (out_row <= h_ext - ROW_W'(2)) &&
                      (out_col >= WW'(1)) && (out_col <= w_eff - WW'(2));
    assign last     = (out_row == h_ext - ROW_W'(1)) && (out_col == w_eff - WW'(1));

    assign col_inc = WW'(r_col) + WW'(1);
    assign wrap    = col_inc == w_eff;

    // Next state
    always_comb begin
        n_cfg_width  = r_cfg_width;
        n_cfg_height = r_cfg_height;
        n_col        = r_col;
        n_row        = r_row;
        n_prev_col   = r_prev_col;
        n_prev_row   = r_prev_row;
        n_prev_valid = r_prev_valid;
        n_center     = r_center;

        if (cfg_hit) begin
            // Store the register and restart the frame
            if (i_cfg_idx == CFG_IDX_WIDTH) begin
                n_cfg_width = i_cfg_data[WIDTH_REG_W-1:0];
            end else begin
                n_cfg_height = i_cfg_data[HEIGHT_REG_W-1:0];
            end
            n_col        = '0;
            n_row        = '0;
            n_prev_col   = '0;
            n_prev_row   = '0;
            n_prev_valid = 1'b0;
        end else if (step) begin
            n_prev_row   = r_row;
            n_prev_col   = r_col;
            n_prev_valid = 1'b1;
            n_center     = ram_rdata[31:16];
            if (wrap) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = CW'(col_inc);
            end
            // Frame done: restart position for the next frame
            if (emit && last) begin
                n_col        = '0;
                n_row        = '0;
                n_prev_col   = '0;
                n_prev_row   = '0;
                n_prev_valid = 1'b0;
            end
        end
    end

    // Output register: hold until taken, load on an emitting step
    always_comb begin
        n_out_valid = r_out_valid && !o_pix.ready;
        n_out_data  = r_out_data;
        if (step && emit) begin
            n_out_valid           = 1'b1;
            n_out_data.out_first  = interior ? median : chain[1].ctr;
            n_out_data.out_second = r_center[7:0];
            n_out_data.out_third  = r_center[15:8];
            n_out_data.frame_end  = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_prev_col   <= '0;
            r_prev_row   <= '0;
            r_prev_valid <= 1'b0;
            r_center     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cfg_width  <= n_cfg_width;
            r_cfg_height <= n_cfg_height;
            r_col        <= n_col;
            r_row        <= n_row;
            r_prev_col   <= n_prev_col;
            r_prev_row   <= n_prev_row;
            r_prev_valid <= n_prev_valid;
            r_center     <= n_center;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out_data;

    // Column position stays inside the row
    `MED3FC_ASSERT(a_col_in_row, WW'(r_col) < w_eff)
    // Row position reaches at most one past the height, after the last drain wrap
    `MED3FC_ASSERT(a_row_bound, r_row <= h_ext + ROW_W'(1))
    // The last pixel of a frame restarts the position
    `MED3FC_ASSERT_NEXT(a_restart_after_last, step && emit && last, r_row == '0 && r_col == '0)
    // A result appears only from an emitting step
    `MED3FC_ASSERT(a_out_source, $rose(r_out_valid) |-> $past(step && emit))

endmodule

`default_nettype wire

// ===== sim/median3x3_first_channel_unit_tb.sv =====
// ------------------------------------------------------------------------
// median3x3_first_channel_unit_tb
// Self-checking testbench for the 3x3 first-channel median filter. A class
// mirrors the line stores and the window to predict every output beat.
// Directed frames come first, then random frames over many frame sizes,
// with random stalls on both channels.
// ------------------------------------------------------------------------
`default_nettype none

module median3x3_first_channel_unit_tb
    import med3fc_pkg::*;
();

    localparam int MAX_W         = 2048;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
    localparam int IDLE_LIMIT    = 5000;  // cycles without any beat before giving up
    localparam int SETTLE_CYCLES = 8;     // output register plus margin
    localparam int MAX_REPORTS   = 10;
    localparam int WIDE_PHASE    = 3;     // phase that runs the widest line
    localparam int WIDE_PIXELS   = 48;    // pixels sent into the widest line
    localparam int HOLD_PHASE    = 1;     // phase that runs the long hold-off

    // Register indexes past the end of the register list; writes there are ignored
    localparam t_cfg_idx CFG_IDX_SPARE_2 = 2'd2;
    localparam t_cfg_idx CFG_IDX_SPARE_3 = 2'd3;

    // ---------------------------------------------------------------------
    // Scoreboard: predicts the output stream from the accepted input beats
    // ---------------------------------------------------------------------
    class median_scoreboard;
        logic [PIX_W-1:0]        older_row [MAX_W];
        logic [PIX_W-1:0]        newer_row [MAX_W];
        logic [7:0]              win [3][3];     // [column][row], column 0 oldest
        logic [15:0]             center_pass;    // second and third channel of the center
        int unsigned             col_pos;
        int unsigned             row_pos;
        int unsigned             last_row;
        int unsigned             last_col;
        bit                      last_valid;
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        t_pix_out                expected_pixels [$];
        int                      errors;

        function new();
            foreach (older_row[i]) begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            center_pass = '0;
            width_reg   = WIDTH_RESET;
            height_reg  = HEIGHT_RESET;
            errors      = 0;
            restart();
        endfunction

        function void restart();
            col_pos    = 0;
            row_pos    = 0;
            last_row   = 0;
            last_col   = 0;
            last_valid = 1'b0;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > MAX_W) w = MAX_W;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h < MIN_DIM) h = MIN_DIM;
            return h;
        endfunction

        function logic [7:0] window_median();
            logic [7:0] vals [9];
            int         n;
            n = 0;
            foreach (win[i, j]) begin
                vals[n] = win[i][j];
                n++;
            end
            vals.sort();
            return vals[4];
        endfunction

        function void apply_reg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IDX_WIDTH: begin
                    width_reg = data[WIDTH_REG_W-1:0];
                    restart();
                end
                CFG_IDX_HEIGHT: begin
                    height_reg = data[HEIGHT_REG_W-1:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        function void note_pixel_in(t_pix_in beat);
            int unsigned      w;
            int unsigned      h;
            int unsigned      ci;
            int unsigned      r;
            int unsigned      c;
            int               k;
            logic [PIX_W-1:0] pix;
            logic [PIX_W-1:0] above2;
            logic [PIX_W-1:0] above1;
            t_pix_out         res;
            bit               frame_done;
            w          = eff_width();
            h          = eff_height();
            pix        = '0;
            frame_done = 1'b0;
            if (row_pos < h) begin
                // Drop a flush while the frame still expects pixels
                if (beat.flush) return;
                pix = {beat.chan_third, beat.chan_second, beat.chan_first};
            end
            // Past the last row every beat drains, whatever its flush bit
            ci     = (col_pos < w) ? col_pos : 0;
            above2 = older_row[ci];
            above1 = newer_row[ci];
            for (k = 0; k < 3; k++) begin
                win[0][k] = win[1][k];
                win[1][k] = win[2][k];
            end
            win[2][0]     = above2[7:0];
            win[2][1]     = above1[7:0];
            win[2][2]     = pix[7:0];
            older_row[ci] = above1;
            newer_row[ci] = pix;
            if (last_valid && last_row >= 1) begin
                r = last_row - 1;
                c = last_col;
                res.out_first = win[1][1];
                if (r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2)
                    res.out_first = window_median();
                res.out_second  = center_pass[7:0];
                res.out_third   = center_pass[15:8];
                frame_done      = (r == h - 1) && (c == w - 1);
                res.frame_end   = frame_done;
                expected_pixels = {expected_pixels, res};
            end
            center_pass = above1[23:8];
            last_row    = row_pos;
            last_col    = ci;
            last_valid  = 1'b1;
            ci++;
            if (ci >= w) begin
                ci = 0;
                row_pos++;
            end
            col_pos = ci;
            if (frame_done) restart();
        endfunction

        function void check_pixel_out(t_pix_out got);
            t_pix_out want;
            if (expected_pixels.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("ERROR: unexpected output beat %0d/%0d/%0d end=%0b",
                             got.out_first, got.out_second, got.out_third, got.frame_end);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.out_first !== want.out_first || got.out_second !== want.out_second ||
                got.out_third !== want.out_third || got.frame_end !== want.frame_end) begin
                if (errors < MAX_REPORTS)
                    $display("ERROR: expected %0d/%0d/%0d end=%0b, got %0d/%0d/%0d end=%0b",
                             want.out_first, want.out_second, want.out_third, want.frame_end,
                             got.out_first, got.out_second, got.out_third, got.frame_end);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ---------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit          no_idle      = 1'b0;  // set for stretches with no gaps on either side
    bit          hold_off_req = 1'b0;  // asks the receiver for one long hold-off
    int unsigned items_sent   = 0;
    int unsigned stall_cycles = 0;

    median_scoreboard sb = new();

    med3fc_stream_if #(.T(t_pix_in))  pix_in_if ();
    med3fc_stream_if #(.T(t_pix_out)) pix_out_if ();

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    median3x3_first_channel_unit #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_pix     (pix_in_if.sink),
        .o_pix     (pix_out_if.source)
    );

    // ---------------------------------------------------------------------
    // Monitor: sample both channels and the write port at every rising edge.
    // The block updates through nonblocking assignments, so the values seen
    // here are the ones that the edge captured.
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            // Check outputs before noting inputs: no beat leaves in the cycle it enters
            if (pix_out_if.valid && pix_out_if.ready) sb.check_pixel_out(pix_out_if.data);
            if (pix_in_if.valid && pix_in_if.ready) sb.note_pixel_in(pix_in_if.data);
            if (cfg_we) sb.apply_reg_write(cfg_idx, cfg_data);
        end
    end

    // Watchdog: give up when no beat and no write has moved for too long
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (pix_in_if.valid && pix_in_if.ready) ||
            (pix_out_if.valid && pix_out_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Gap length for either side: mostly none or short, a few long
    function automatic int pick_gap();
        int unsigned roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        pix_out_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                // Hold ready low long enough for the block to fill and stall its input
                hold_off_req = 1'b0;
                pix_out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    pix_out_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pix_out_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // ---------------------------------------------------------------------
    // Sender tasks
    // ---------------------------------------------------------------------
    function automatic t_pix_in pix_beat(bit flush, logic [7:0] first, logic [7:0] second,
                                         logic [7:0] third);
        t_pix_in b;
        b.flush       = flush;
        b.chan_first  = first;
        b.chan_second = second;
        b.chan_third  = third;
        return b;
    endfunction

    // Bias toward the byte extremes so medians see ties at 0 and 255
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix_in random_beat(bit flush);
        return pix_beat(flush, rand_byte(), rand_byte(), rand_byte());
    endfunction

    // Offer one beat after a random gap; hold it until the block takes it
    task automatic send_beat(input t_pix_in beat);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in_if.valid <= 1'b1;
        pix_in_if.data  <= beat;
        do @(posedge clk); while (!pix_in_if.ready);
    endtask

    // Pause the sender until every expected beat is out, then let the block settle
    task automatic wait_drained();
        pix_in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stream one frame (or its first npix pixels), then drain it
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned npix);
        int unsigned drain;
        for (int unsigned i = 0; i < npix; i++) begin
            // Sprinkle flushes into the frame; the block must drop them
            if ($urandom_range(0, 15) == 0) send_beat(random_beat(1'b1));
            send_beat(random_beat(1'b0));
            items_sent++;
        end
        if (npix < w * h) return;
        case ($urandom_range(0, 9))
            0: drain = $urandom_range(0, w);             // cut the drain short
            1: drain = w + 1 + $urandom_range(1, 3);     // run over into the next frame
            default: drain = w + 1;
        endcase
        // Drain beats carry random flush bits and data; both must act as flushes
        for (int unsigned i = 0; i < drain; i++) begin
            send_beat(random_beat(1'($urandom_range(0, 1))));
            items_sent++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Directed part: smallest frame, byte extremes, flushes in and after it
    // ---------------------------------------------------------------------
    task automatic run_directed();
        int         i;
        logic [7:0] first;
        // Both registers below the minimum: the frame is 3x3. Upper width bits are ignored.
        write_reg(CFG_IDX_WIDTH, 16'hF000);
        write_reg(CFG_IDX_HEIGHT, 16'h0000);
        // Corners 200, edges 255, center 0: the median (200) differs from the center
        for (i = 0; i < 9; i++) begin
            first = (i == 4) ? 8'd0 : ((i % 2 == 0) ? 8'd200 : 8'd255);
            send_beat(pix_beat(1'b0, first, (i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF));
            // A flush inside the frame must be dropped
            if (i == 4) send_beat(pix_beat(1'b1, 8'hFF, 8'hFF, 8'hFF));
        end
        // Drain with width + 1 beats; pixels here act as flushes too
        send_beat(pix_beat(1'b1, 8'h00, 8'h00, 8'h00));
        send_beat(pix_beat(1'b0, 8'hFF, 8'hFF, 8'hFF));
        send_beat(pix_beat(1'b1, 8'hFF, 8'hFF, 8'hFF));
        send_beat(pix_beat(1'b0, 8'h00, 8'h00, 8'h00));
        // Next frame restarts at the origin; stop partway in
        for (i = 0; i < 5; i++) send_beat(pix_beat(1'b0, 8'(i * 61), 8'(i * 17), 8'(255 - i)));
        wait_drained();
        // Writes past the register list must not restart the frame
        write_reg(CFG_IDX_SPARE_2, 16'hFFFF);
        write_reg(CFG_IDX_SPARE_3, 16'h5A5A);
        for (i = 5; i < 9; i++) send_beat(pix_beat(1'b0, 8'(i * 29), 8'hC3, 8'h3C));
        for (i = 0; i < 4; i++) send_beat(pix_beat(1'b1, 8'h00, 8'h00, 8'h00));
        wait_drained();
    endtask

    // ---------------------------------------------------------------------
    // Random part: phases of one register setting each, several frames per phase
    // ---------------------------------------------------------------------
    task automatic run_random();
        int unsigned           phase;
        int unsigned           w_eff;
        int unsigned           h_eff;
        int unsigned           nframes;
        int unsigned           npix;
        int unsigned           mode;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        phase  = 0;
        w_data = 16'd3;
        h_data = 16'd3;
        while (items_sent < RANDOM_ITEMS) begin
            wait_drained();
            mode = $urandom_range(0, 7);
            if (phase == WIDE_PHASE) begin
                // All width bits set: clamps to the widest line
                w_data = 16'hFFFF;
                h_data = 16'd3;
            end else begin
                if (mode != 1) begin
                    case ($urandom_range(0, 9))
                        0: w_data = 16'($urandom_range(0, 2));
                        1: w_data = 16'd3;
                        2: w_data = 16'($urandom_range(13, 40));
                        default: w_data = 16'($urandom_range(4, 12));
                    endcase
                    w_data[15:12] = 4'($urandom_range(0, 15));
                end
                if (mode != 0) begin
                    case ($urandom_range(0, 19))
                        0, 1: h_data = 16'($urandom_range(0, 2));
                        2: h_data = 16'hFFFF;
                        3: h_data = 16'($urandom_range(16, 65535));
                        4, 5, 6, 7: h_data = 16'($urandom_range(7, 12));
                        default: h_data = 16'($urandom_range(3, 6));
                    endcase
                end
            end
            // Rewrite both in and after the wide phase; otherwise now and then only one
            if (phase == WIDE_PHASE + 1 || phase == WIDE_PHASE) mode = 7;
            if (mode == 2) write_reg(CFG_IDX_SPARE_2, 16'($urandom_range(0, 65535)));
            if (mode == 3) write_reg(CFG_IDX_SPARE_3, 16'($urandom_range(0, 65535)));
            if (mode != 1) write_reg(CFG_IDX_WIDTH, w_data);
            if (mode != 0) write_reg(CFG_IDX_HEIGHT, h_data);

            w_eff = w_data[WIDTH_REG_W-1:0];
            if (w_eff < MIN_DIM) w_eff = MIN_DIM;
            if (w_eff > MAX_W) w_eff = MAX_W;
            h_eff = (h_data < MIN_DIM) ? MIN_DIM : h_data;

            no_idle = ($urandom_range(0, 5) == 0);
            if (phase == HOLD_PHASE) begin
                // Keep the sender busy while the receiver holds off
                no_idle      = 1'b1;
                hold_off_req = 1'b1;
            end
            nframes = (phase == WIDE_PHASE) ? 1 : $urandom_range(1, 3);
            for (int unsigned f = 0; f < nframes; f++) begin
                npix = w_eff * h_eff;
                // Tall or wide frames: send only part of the frame, then restart by a write
                if (npix > 600)
                    npix = (phase == WIDE_PHASE) ? WIDE_PIXELS : w_eff * $urandom_range(2, 5);
                send_frame(w_eff, h_eff, npix);
                if (npix < w_eff * h_eff) break;
                if ($urandom_range(0, 6) == 0) wait_drained();
            end
            phase++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_IDX_WIDTH;
        cfg_data        <= '0;
        pix_in_if.valid <= 1'b0;
        pix_in_if.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        wait_drained();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
